[design/button_debounce_edge_repeat_core_assert.svh]
// Assertion macros used by the checker file of this block.
// Each macro takes a label, the clock, the active-low reset, a condition
// and a consequence, and reports through $error.
`ifndef BUTTON_DEBOUNCE_EDGE_REPEAT_CORE_ASSERT_SVH
`define BUTTON_DEBOUNCE_EDGE_REPEAT_CORE_ASSERT_SVH

// Consequence must hold in the same cycle as the condition.
`define BDER_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle property violated");

// Consequence must hold in the cycle after the condition.
`define BDER_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle property violated");

`endif

[design/bder_pkg.sv]
`default_nettype none

package bder_pkg;

	// Field and register widths.
	localparam int unsigned NUM_BUTTONS = 4;
	localparam int unsigned TIME_W      = 32;
	localparam int unsigned CFG_W       = 16;
	localparam int unsigned CMD_W       = 3;

	// Bit positions of the buttons in a raw sample.
	localparam int unsigned BIT_LEFT   = 0;
	localparam int unsigned BIT_DOWN   = 1;
	localparam int unsigned BIT_RIGHT  = 2;
	localparam int unsigned BIT_ROTATE = 3;

	// Register indexes and reset values.
	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_REPEAT   = 1'b1;
	localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd20;
	localparam logic [CFG_W-1:0] REPEAT_RESET   = 16'd80;

	// Command codes.
	typedef enum logic [CMD_W-1:0] {
		CMD_NONE   = 3'd0,
		CMD_ROTATE = 3'd1,
		CMD_LEFT   = 3'd2,
		CMD_RIGHT  = 3'd3,
		CMD_DOWN   = 3'd4
	} cmd_t;

	// What one debounce lane reports for the current request.
	typedef struct packed {
		logic stable;
		logic latch;
	} lane_res_t;

	// What the merging stage decides for the current request.
	typedef struct packed {
		cmd_t                   cmd;
		logic [NUM_BUTTONS-1:0] latch;
		logic                   repeat_fire;
	} merge_res_t;

endpackage

`default_nettype wire

[design/bder_lane.sv]
`default_nettype none

module bder_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          raw_bit,
	input  logic                          latch_bit,
	input  logic [bder_pkg::TIME_W-1:0]   now_time,
	input  logic [bder_pkg::CFG_W-1:0]    debounce_time,
	output bder_pkg::lane_res_t           res
);
	import bder_pkg::*;

	logic              stable_q;
	logic [TIME_W-1:0] change_time_q;
	logic [TIME_W-1:0] elapsed;
	logic [TIME_W-1:0] change_time_next;
	logic              differs;
	logic              settled;
	logic              take;

	// Elapsed time since the last change point, modulo the timestamp width.
	always_comb begin
		elapsed = now_time - change_time_q;
		differs = raw_bit ^ stable_q;
		settled = elapsed >= {{(TIME_W-CFG_W){1'b0}}, debounce_time};
		take    = differs & settled;
	end

	// A settled change moves the old level into the latch and takes the raw level.
	always_comb begin
		res.stable       = take ? raw_bit : stable_q;
		res.latch        = take ? stable_q : latch_bit;
		change_time_next = (differs & ~settled) ? change_time_q : now_time;
	end

	// Per-button debounce state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q      <= 1'b0;
			change_time_q <= '0;
		end else if (accept) begin
			stable_q      <= res.stable;
			change_time_q <= change_time_next;
		end
	end

endmodule

`default_nettype wire

[design/bder_merge.sv]
`default_nettype none

module bder_merge (
	input  logic [bder_pkg::NUM_BUTTONS-1:0] stable,
	input  logic [bder_pkg::NUM_BUTTONS-1:0] latch,
	input  logic [bder_pkg::TIME_W-1:0]      now_time,
	input  logic [bder_pkg::TIME_W-1:0]      last_repeat_time,
	input  logic [bder_pkg::CFG_W-1:0]       repeat_interval,
	output bder_pkg::merge_res_t             res
);
	import bder_pkg::*;

	logic [TIME_W-1:0]      since_repeat;
	logic                   repeat_due;
	logic [NUM_BUTTONS-1:0] fresh;

	// A button is fresh when it is stably pressed and not yet latched.
	always_comb begin
		fresh        = stable & ~latch;
		since_repeat = now_time - last_repeat_time;
		repeat_due   = since_repeat >= {{(TIME_W-CFG_W){1'b0}}, repeat_interval};
	end

	// Rotate, left and right in priority, then down with auto-repeat.
	always_comb begin
		res.cmd         = CMD_NONE;
		res.latch       = latch & stable;
		res.repeat_fire = 1'b0;
		priority if (fresh[BIT_ROTATE]) begin
			res.cmd               = CMD_ROTATE;
			res.latch             = latch;
			res.latch[BIT_ROTATE] = 1'b1;
		end else if (fresh[BIT_LEFT]) begin
			res.cmd             = CMD_LEFT;
			res.latch           = latch;
			res.latch[BIT_LEFT] = 1'b1;
		end else if (fresh[BIT_RIGHT]) begin
			res.cmd              = CMD_RIGHT;
			res.latch            = latch;
			res.latch[BIT_RIGHT] = 1'b1;
		end else if (stable[BIT_DOWN] && (!latch[BIT_DOWN] || repeat_due)) begin
			res.cmd             = CMD_DOWN;
			res.latch           = latch;
			res.latch[BIT_DOWN] = 1'b1;
			res.repeat_fire     = 1'b1;
		end else begin
			// No command: latches stay only on buttons that are still held.
			res.cmd   = CMD_NONE;
			res.latch = latch & stable;
		end
	end

endmodule

`default_nettype wire

[design/button_debounce_edge_repeat_core.sv]
// Debounced four-button poller with edge commands and auto-repeat on down.
// Input channel: in_valid / in_stall carry one poll request (raw_buttons,
// now_time). Output channel: out_valid / out_stall carry one command per poll.
// Each button has its own debounce lane; a merging stage picks the command
// and updates the press latches and the repeat timestamp.
// The command of a poll is registered and appears on the output in the cycle
// after the poll is accepted. One poll per cycle while no command is stalled;
// the whole state update is one register stage fed by the four lane compares
// and the merge logic. When the receiver stalls, the command register holds
// its value and in_stall is raised, so new polls wait until the command is
// taken; a poll is taken in the same cycle that the held command leaves.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 debounce_time, 1 repeat_interval) at a rising edge; write it only while
// no poll is in flight.
// Reset (arst_n low, asynchronous): debounce_time 20, repeat_interval 80,
// all levels, latches and timestamps zero, no command pending.
`default_nettype none

module button_debounce_edge_repeat_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [bder_pkg::NUM_BUTTONS-1:0]   raw_buttons,
	input  logic [bder_pkg::TIME_W-1:0]        now_time,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [bder_pkg::CMD_W-1:0]         command,
	input  logic                               cfg_wr_en,
	input  logic                               cfg_index,
	input  logic [bder_pkg::CFG_W-1:0]         cfg_data
);
	import bder_pkg::*;

	logic [CFG_W-1:0]       debounce_time_q;
	logic [CFG_W-1:0]       repeat_interval_q;
	logic [NUM_BUTTONS-1:0] latch_q;
	logic [TIME_W-1:0]      last_repeat_q;
	logic                   out_valid_q;
	cmd_t                   cmd_q;
	logic                   accept;
	lane_res_t              lane_res [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] lane_stable;
	logic [NUM_BUTTONS-1:0] lane_latch;
	merge_res_t             merge_res;

	// A request is taken whenever the output register is empty or draining.
	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign command   = cmd_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_time_q   <= DEBOUNCE_RESET;
			repeat_interval_q <= REPEAT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DEBOUNCE: debounce_time_q   <= cfg_data;
				REG_REPEAT:   repeat_interval_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	// One debounce lane per button.
	for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
		bder_lane u_lane (
			.clk           (clk),
			.arst_n        (arst_n),
			.accept        (accept),
			.raw_bit       (raw_buttons[b]),
			.latch_bit     (latch_q[b]),
			.now_time      (now_time),
			.debounce_time (debounce_time_q),
			.res           (lane_res[b])
		);
		assign lane_stable[b] = lane_res[b].stable;
		assign lane_latch[b]  = lane_res[b].latch;
	end

	// Command selection across lanes.
	bder_merge u_merge (
		.stable           (lane_stable),
		.latch            (lane_latch),
		.now_time         (now_time),
		.last_repeat_time (last_repeat_q),
		.repeat_interval  (repeat_interval_q),
		.res              (merge_res)
	);

	// Press latches and repeat timestamp.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q       <= '0;
			last_repeat_q <= '0;
		end else if (accept) begin
			latch_q <= merge_res.latch;
			if (merge_res.repeat_fire) begin
				last_repeat_q <= now_time;
			end
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= merge_res.cmd;
		end
	end

endmodule

`default_nettype wire

[design/bder_checker.sv]
`default_nettype none
`include "button_debounce_edge_repeat_core_assert.svh"

module bder_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [bder_pkg::CMD_W-1:0]  command
);
	import bder_pkg::*;

	// Only defined command codes leave the block.
	`BDER_ASSERT_SAME(a_cmd_code, clk, arst_n, out_valid, command <= CMD_DOWN)

	// Every accepted poll produces a command in the next cycle.
	`BDER_ASSERT_NEXT(a_poll_result, clk, arst_n, in_valid && !in_stall, out_valid)

	// Polls wait only behind a stalled pending command.
	`BDER_ASSERT_SAME(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)

	// A stalled command holds.
	`BDER_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(command))

endmodule

bind button_debounce_edge_repeat_core bder_checker u_bder_checker (.*);

`default_nettype wire
